/* design/cas_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cas_pkg
// Shared constants, types and helper functions for the cave smoothing core.
// ----------------------------------------------------------------------------
package cas_pkg;

  // frame limits
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // port widths fixed by the interface
  localparam int CFG_W = 9;
  localparam int IDX_W = 2;
  localparam int OUT_W = 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COL_COUNT = IDX_W'(1);

  localparam int unsigned MIN_DIM   = 3;
  localparam int unsigned RESET_DIM = 256;

  // 4-5 rule thresholds
  localparam int WALL_HI = 5;
  localparam int WALL_LO = 3;

  // window layout: bit col*3+row, col 2 newest, row 2 newest
  localparam int WIN_BITS     = 9;
  localparam int WIN_CENTER   = 4;
  localparam int WIN_PREV_MID = 7;

  // result queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic             wall;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cas_result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                input int unsigned top);
    int unsigned x;
    x = 32'(v);
    if (x < MIN_DIM) begin
      x = MIN_DIM;
    end else if (x > top) begin
      x = top;
    end
    return DIM_W'(x);
  endfunction

  function automatic logic [3:0] neighbour_count(input logic [WIN_BITS-1:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WIN_BITS; i++) begin
      if (i != WIN_CENTER) n = n + 4'(w[i]);
    end
    return n;
  endfunction

  // >= 5 walls -> wall, <= 3 walls -> open, exactly 4 -> keep
  function automatic logic smooth_rule(input logic [WIN_BITS-1:0] w);
    logic [3:0] n;
    n = neighbour_count(w);
    if (n >= 4'(WALL_HI)) return 1'b1;
    if (n <= 4'(WALL_LO)) return 1'b0;
    return w[WIN_CENTER];
  endfunction

endpackage
`default_nettype wire

/* design/cave_automaton_smoothing_pass_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_pass_core
// One 4-5 cellular automaton smoothing pass over a raster-ordered wall bitmap.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  input    | in_valid/in_ready   | action, wall_in
//  output   | out_valid/out_ready | wall_out, out_row, out_col, last
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One input transfer per clock while in_ready is high; a result reaches
//  the output port through the stage-two register, which holds the line
//  buffer read, and then the result queue.
//  The rate is set by the line buffer RAM ports: one read and one write of
//  each buffer per cycle.
//  Reset clears frame counters and window; line buffers need no clearing
//  since every value that reaches a result was written earlier in the frame.
//  Output stalls are absorbed by a three-entry result queue; in_ready drops
//  only when the queue plus the item in flight could fill it.
//
module cave_automaton_smoothing_pass_core import cas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // input cells
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic             wall_in,
  // results
  output logic             out_valid,
  input  logic             out_ready,
  output logic             wall_out,
  output logic [OUT_W-1:0] out_row,
  output logic [OUT_W-1:0] out_col,
  output logic             last,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // frame size (already clamped)
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic [DIM_W-1:0] rows_m1;
  logic [DIM_W-1:0] cols_m1;

  // input and output raster positions
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_done;   // whole frame in, draining the tail
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;

  // 3x3 neighbourhood
  logic [WIN_BITS-1:0] window;
  logic [WIN_BITS-1:0] win_next;

  // accept-stage decode
  logic             in_xfer;
  logic             is_tail;
  logic             is_cell;
  logic             has_out;
  logic             in_col_end;
  logic             in_row_end;
  logic             out_col_end;
  logic             out_row_end;
  logic             frame_last;
  logic             border;
  logic [COL_W-1:0] rd_addr;
  logic             fwd_hit;
  logic             cfg_hit;

  // second stage: line buffer data is back
  logic             s1_valid;
  logic             s1_tail;
  logic             s1_bot;
  logic             s1_has_out;
  logic             s1_ci_zero;
  logic             s1_border;
  logic             s1_sel_mid;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_last;
  logic [COL_W-1:0] s1_addr;
  logic             s1_fwd;
  logic             s1_fwd_top;
  logic             s1_fwd_mid;
  logic             s1_wr;

  logic             top_q;
  logic             mid_q;
  logic             top_v;
  logic             mid_v;
  logic             smooth;

  cas_result_t             res;
  cas_result_t             head;
  logic                    res_push;
  logic [FIFO_CNT_W-1:0]   level;

  assign rows_m1 = rows - DIM_W'(1);
  assign cols_m1 = cols - DIM_W'(1);

  assign in_xfer = in_valid && in_ready;
  assign is_tail = in_done;                 // any item drains the tail
  assign is_cell = !in_done && !action;     // early flush ticks are dropped

  assign in_col_end  = (DIM_W'(in_col) == cols_m1);
  assign in_row_end  = (DIM_W'(in_row) == rows_m1);
  assign out_col_end = (DIM_W'(out_col_q) == cols_m1);
  assign out_row_end = (DIM_W'(out_row_q) == rows_m1);
  assign frame_last  = out_row_end && out_col_end;

  // output trails input by one row and one column
  assign has_out = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign border  = (out_row_q == '0) || (out_col_q == '0) || out_row_end || out_col_end;

  // tail reads: last column of row rows-2 from the top buffer, then the
  // final row from the mid buffer; both at the output column
  assign rd_addr = is_tail ? out_col_q : in_col;

  // write-back of the item in stage two hits the entry being read now
  assign s1_wr   = s1_valid && !s1_tail;
  assign fwd_hit = s1_wr && (rd_addr == s1_addr);

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == REG_ROW_COUNT) ||
                                   (cfg_index == REG_COL_COUNT));

  // room for the item in flight plus this one
  assign in_ready = ((FIFO_CNT_W+1)'(level) + (FIFO_CNT_W+1)'(s1_valid))
                    < (FIFO_CNT_W+1)'(FIFO_DEPTH);

  // line buffers: top holds the row two above, mid the row above
  cas_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_top_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr),
    .wdata (mid_v),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (top_q)
  );

  cas_ram #(.WIDTH(1), .DEPTH(MAX_COLS)) u_mid_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr),
    .wdata (s1_bot),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (mid_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= clamp_dim(CFG_W'(RESET_DIM), MAX_ROWS);
      cols      <= clamp_dim(CFG_W'(RESET_DIM), MAX_COLS);
      in_col    <= '0;
      in_row    <= '0;
      in_done   <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_valid  <= 1'b0;
      window    <= '0;
    end else begin
      s1_valid <= in_xfer && (is_tail || is_cell);

      if (s1_wr) window <= win_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_COUNT: rows <= clamp_dim(cfg_data, MAX_ROWS);
          REG_COL_COUNT: cols <= clamp_dim(cfg_data, MAX_COLS);
          default: ;
        endcase
      end

      if (cfg_hit) begin
        // a register write abandons the frame; buffers are kept
        in_col    <= '0;
        in_row    <= '0;
        in_done   <= 1'b0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (in_xfer) begin
        if (is_tail) begin
          if (frame_last) begin
            // frame done, next cell starts a new one
            in_col    <= '0;
            in_row    <= '0;
            in_done   <= 1'b0;
            out_col_q <= '0;
            out_row_q <= '0;
          end else if (out_col_end) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + ROW_W'(1);
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end else if (is_cell) begin
          if (in_col_end) begin
            in_col <= '0;
            if (in_row_end) begin
              in_row  <= '0;
              in_done <= 1'b1;
            end else begin
              in_row <= in_row + ROW_W'(1);
            end
          end else begin
            in_col <= in_col + COL_W'(1);
          end
          if (has_out) begin
            if (out_col_end) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + ROW_W'(1);
            end else begin
              out_col_q <= out_col_q + COL_W'(1);
            end
          end
        end
      end
    end
  end

  // stage-two payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_tail    <= is_tail;
      s1_bot     <= wall_in;
      s1_has_out <= has_out;
      s1_ci_zero <= (in_col == '0);
      s1_border  <= border;
      s1_sel_mid <= out_row_end;
      s1_row     <= out_row_q;
      s1_col     <= out_col_q;
      s1_last    <= frame_last;
      s1_addr    <= rd_addr;
      s1_fwd     <= fwd_hit;
      s1_fwd_top <= mid_v;
      s1_fwd_mid <= s1_bot;
    end
  end

  assign top_v = s1_fwd ? s1_fwd_top : top_q;
  assign mid_v = s1_fwd ? s1_fwd_mid : mid_q;

  // shift the new column in at the top end
  assign win_next = {s1_bot, mid_v, top_v, window[WIN_BITS-1:3]};
  assign smooth   = s1_border ? win_next[WIN_CENTER] : smooth_rule(win_next);

  always_comb begin
    res.row  = s1_row;
    res.col  = s1_col;
    res.last = s1_tail && s1_last;
    if (s1_tail) begin
      res.wall = s1_sel_mid ? mid_v : top_v;
    end else if (s1_ci_zero) begin
      // right border cell of the row two above, seen by the previous cell as mid
      res.wall = window[WIN_PREV_MID];
    end else begin
      res.wall = smooth;
    end
  end

  assign res_push = s1_valid && (s1_tail || s1_has_out);

  cas_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .level     (level)
  );

  assign wall_out = head.wall;
  assign out_row  = OUT_W'(head.row);
  assign out_col  = OUT_W'(head.col);
  assign last     = head.last;

`ifndef NO_ASSERTIONS
  a_tail_rows: assert property (@(posedge clk) disable iff (rst)
    in_done |-> (DIM_W'(out_row_q) >= rows - DIM_W'(2)))
    else $error("tail draining outside the last two rows");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && is_tail && frame_last) |=>
      ((in_col == '0) && (in_row == '0) && !in_done &&
       (out_col_q == '0) && (out_row_q == '0)))
    else $error("positions not cleared after final cell");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid || out_valid))
    else $error("input stalled with nothing pending");
`endif

endmodule
`default_nettype wire

/* design/cas_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module cas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/cas_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cas_out_fifo
// Small result queue in front of the output port; decouples output stalls.
// ----------------------------------------------------------------------------
module cas_out_fifo import cas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cas_result_t           push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cas_result_t           head,
  output logic [FIFO_CNT_W-1:0] level
);

  cas_result_t           entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        level <= level - FIFO_CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result pushed into full queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (level == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

  a_level_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level == $past(level) + FIFO_CNT_W'(1)))
    else $error("queue level did not follow push");
`endif

endmodule
`default_nettype wire
